FILE: rtl/core/itoa_pkg.sv
// Shared types and constants for the int32_to_decimal_ascii block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package itoa_pkg;

   // Field widths
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned DIGIT_W       = 4;
   localparam int unsigned NUM_DIGITS    = 10;
   localparam int unsigned BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int unsigned DIG_IDX_W     = 4;

   // Binary to BCD converter: bits consumed per cycle and cycle count
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned NUM_STEPS     = VALUE_W / BITS_PER_STEP;
   localparam int unsigned STEP_CNT_W    = 3;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture sign and magnitude of a new item
      logic step;        // run one converter step
      logic lead;        // point at the leading nonzero digit
      logic next_digit;  // move to the next lower digit
      logic sel_sign;    // present the minus sign on the output
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic neg;         // value is negative
      logic last;        // current digit is the units digit
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/itoa_req_if.sv
// Input channel: valid/ready handshake carrying one signed 32-bit value.
// Depends on itoa_pkg.
`default_nettype none

interface itoa_req_if;
   import itoa_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/itoa_rsp_if.sv
// Result channel: valid/ready handshake carrying one ASCII character and its end flag.
// Depends on itoa_pkg.
`default_nettype none

interface itoa_rsp_if;
   import itoa_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ascii_char;
   logic              last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/itoa_dp.sv
// Datapath: sign/magnitude capture, shift-add-3 binary to BCD converter,
// leading digit search and character output. Depends on itoa_pkg.
`default_nettype none

module itoa_dp (
   input  logic                                clock,
   input  logic [itoa_pkg::VALUE_W-1:0]        value,
   input  itoa_pkg::dp_cmd_type                cmd,
   output itoa_pkg::dp_status_type             status,
   output logic [itoa_pkg::CHAR_W-1:0]         ascii_char,
   output logic                                last_char
);
   import itoa_pkg::*;

   logic                 neg_ff, neg_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [DIG_IDX_W-1:0] ptr_ff, ptr_in;

   logic [VALUE_W-1:0]   mag;
   logic [VALUE_W-1:0]   bin_step;
   logic [BCD_W-1:0]     bcd_step;
   logic [DIG_IDX_W-1:0] lead_idx;
   logic [DIGIT_W-1:0]   digits [NUM_DIGITS];
   logic [DIGIT_W-1:0]   cur_digit;

   // Magnitude as unsigned negation; the most negative value maps to 2^31
   assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

   // Four shift-add-3 iterations per cycle
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d*DIGIT_W +: DIGIT_W] >= 4'd5)
               bcd_step[d*DIGIT_W +: DIGIT_W] = bcd_step[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end
         bcd_step = {bcd_step[BCD_W-2:0], bin_step[VALUE_W-1]};
         bin_step = {bin_step[VALUE_W-2:0], 1'b0};
      end
   end

   // Unpack digits and find the highest nonzero one (units if all zero)
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         digits[d] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != '0)
            lead_idx = DIG_IDX_W'(d);
      end
   end

   // Register next values
   always_comb begin
      neg_in = neg_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ptr_in = ptr_ff;
      if (cmd.load) begin
         neg_in = value[VALUE_W-1];
         bin_in = mag;
         bcd_in = '0;
      end else if (cmd.step) begin
         bin_in = bin_step;
         bcd_in = bcd_step;
      end
      if (cmd.lead)
         ptr_in = lead_idx;
      else if (cmd.next_digit)
         ptr_in = ptr_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ptr_ff <= ptr_in;
   end

   // Character output
   assign cur_digit  = digits[ptr_ff];
   assign ascii_char = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
   assign last_char  = !cmd.sel_sign && (ptr_ff == '0);

   assign status.neg  = neg_ff;
   assign status.last = (ptr_ff == '0);

endmodule

`default_nettype wire

FILE: rtl/core/itoa_ctrl.sv
// Controller: state machine that sequences load, conversion, leading digit
// search and character output. Depends on itoa_pkg.
`default_nettype none

module itoa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  itoa_pkg::dp_status_type status,
   output itoa_pkg::dp_cmd_type    cmd
);
   import itoa_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  conv_done;

   assign conv_done = (cnt_ff == STEP_CNT_W'(NUM_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CONV;
         ST_CONV:  if (conv_done) state_in = ST_LEAD;
         ST_LEAD:  state_in = status.neg ? ST_SIGN : ST_DIGIT;
         ST_SIGN:  if (rsp_ready) state_in = ST_DIGIT;
         ST_DIGIT: if (rsp_ready && status.last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Step counter runs only during conversion
   assign cnt_in = (state_ff == ST_CONV) ? cnt_ff + 1'b1 : '0;

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONV:  cmd.step = 1'b1;
         ST_LEAD:  cmd.lead = 1'b1;
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
         end
         ST_DIGIT: begin
            rsp_valid      = 1'b1;
            cmd.next_digit = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/int32_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII, one character per result item.
// After an input is accepted, the converter takes four bits per step over all
// 32 bits, then the leading digit search runs; characters then go out one per
// cycle while the receiver is ready, 1 to 11 per value. A new input is taken
// only after the last character: the BCD converter and output slot are shared.
// Reset: synchronous, active high; returns the controller to idle.
`default_nettype none

module int32_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_if,
   itoa_rsp_if.source rsp_if
);
   import itoa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Conversion datapath
   itoa_dp u_dp (
      .clock      (clock),
      .value      (req_if.value),
      .cmd        (cmd),
      .status     (status),
      .ascii_char (rsp_if.ascii_char),
      .last_char  (rsp_if.last_char)
   );

`ifndef SYNTHESIS
   // Minus sign never ends a run
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.last_char |-> rsp_if.ascii_char != CHAR_MINUS)
      else $error("minus sign flagged as last character");

   // Only digits or a minus sign leave the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.ascii_char == CHAR_MINUS) ||
                       (rsp_if.ascii_char >= CHAR_ZERO && rsp_if.ascii_char <= CHAR_NINE))
      else $error("output character out of range");

   // One item at a time: no input taken while characters are pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !rsp_if.valid)
      else $error("input ready while output valid");

   // Conversion runs before any character appears
   a_conv_first: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !rsp_if.valid && !req_if.ready)
      else $error("output or input active right after accept");
`endif

endmodule

`default_nettype wire

FILE: test/tb_int32_to_decimal_ascii.sv
`timescale 1ns / 100ps
// Self-checking testbench for int32_to_decimal_ascii: drives signed values, predicts
// the decimal character stream and checks every character and its end flag.
// Depends on itoa_pkg, itoa_req_if, itoa_rsp_if and the int32_to_decimal_ascii RTL.

module tb_int32_to_decimal_ascii;
   import itoa_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS  = 63;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last_char;
   } text_char_type;

   // Expected character stream and mismatch bookkeeping
   class text_scoreboard;
      text_char_type pending_chars[$];
      int unsigned mismatches = 0;

      task report(input string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // Decimal text of one accepted value, appended to the expected stream
      function void note_value(input logic [VALUE_W-1:0] value);
         logic              neg;
         logic [VALUE_W-1:0] mag;
         logic [CHAR_W-1:0] digs[NUM_DIGITS];
         int                nd;
         text_char_type     tc;
         neg = value[VALUE_W-1];
         mag = neg ? (~value + 1'b1) : value;
         nd  = 0;
         do begin
            digs[nd] = CHAR_ZERO + CHAR_W'(mag % 10);
            nd++;
            mag = mag / 10;
         end while (mag != 0);
         // minus sign is never the final character
         if (neg) begin
            tc.ascii_char = CHAR_MINUS;
            tc.last_char  = 1'b0;
            pending_chars.push_back(tc);
         end
         for (int i = nd - 1; i >= 0; i--) begin
            tc.ascii_char = digs[i];
            tc.last_char  = (i == 0);
            pending_chars.push_back(tc);
         end
      endfunction

      task check_char(input logic [CHAR_W-1:0] ascii_char, input logic last_char);
         text_char_type exp_char;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last=%0b", ascii_char, last_char));
         end else begin
            exp_char = pending_chars.pop_front();
            if (ascii_char !== exp_char.ascii_char)
               report($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                ascii_char, exp_char.ascii_char));
            if (last_char !== exp_char.last_char)
               report($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                last_char, exp_char.last_char, exp_char.ascii_char));
         end
      endtask
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_ready = 1'b0;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_stall_pct = 0;
   int unsigned        cycle_count = 0;
   text_scoreboard     sb = new();

   itoa_req_if req_ch();
   itoa_rsp_if rsp_ch();

   assign req_ch.valid = req_valid;
   assign req_ch.value = req_value;
   assign rsp_ch.ready = rsp_ready;

   int32_to_decimal_ascii u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, updated on the falling edge
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_char(rsp_ch.ascii_char, rsp_ch.last_char);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("int32_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   // Present one value, hold it until accepted; valid stays high for a back-to-back item
   task send_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_value(value);
      @(negedge clock);
   endtask

   // Random value biased toward every text length and the range ends
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      int unsigned        nd;
      logic               neg;
      neg = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: return $urandom;
         1: mag = $urandom_range(99);
         2: begin
            nd = $urandom_range(1, NUM_DIGITS);
            lo = 1;
            for (int i = 1; i < nd; i++) lo = lo * 10;
            hi = (nd == NUM_DIGITS) ? 32'd2147483647 : lo * 10 - 1;
            mag = $urandom_range(hi, lo);
         end
         default: begin
            if ($urandom_range(1)) return 32'h8000_0000 + $urandom_range(3);
            else return 32'h7FFF_FFFF - $urandom_range(3);
         end
      endcase
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   initial begin
      logic [VALUE_W-1:0] directed[$];
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd100, -32'sd7,
                   32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
                   -32'sd1000000000, 32'd999999999, 32'd123456789, -32'sd987654321,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'd1999999999};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed values, no idling
      foreach (directed[i]) send_value(directed[i]);

      // Random values across the idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_value(random_value());
      end
      req_valid <= 1'b0;

      // Drain
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_chars.size() != 0)
         sb.report($sformatf("%0d chars never arrived", sb.pending_chars.size()));

      if (sb.mismatches == 0) begin
         $display("int32_to_decimal_ascii regression: pass");
      end else begin
         $display("int32_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule

FILE: int32_to_decimal_ascii.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_req_if.sv
rtl/core/itoa_rsp_if.sv
rtl/core/itoa_dp.sv
rtl/core/itoa_ctrl.sv
rtl/core/int32_to_decimal_ascii.sv
test/tb_int32_to_decimal_ascii.sv
